// ===== rtl/pfxd_pkg.sv =====
package pfxd_pkg;

   // prefix and escape bytes
   localparam logic [7:0] BYTE_LOCK  = 8'hF0;
   localparam logic [7:0] BYTE_REPNE = 8'hF2;
   localparam logic [7:0] BYTE_REP   = 8'hF3;
   localparam logic [7:0] BYTE_SEGES = 8'h26;
   localparam logic [7:0] BYTE_SEGCS = 8'h2E;
   localparam logic [7:0] BYTE_SEGSS = 8'h36;
   localparam logic [7:0] BYTE_SEGDS = 8'h3E;
   localparam logic [7:0] BYTE_SEGFS = 8'h64;
   localparam logic [7:0] BYTE_SEGGS = 8'h65;
   localparam logic [7:0] BYTE_OPSZ  = 8'h66;
   localparam logic [7:0] BYTE_ADSZ  = 8'h67;
   localparam logic [7:0] BYTE_VEX2  = 8'hC5;
   localparam logic [7:0] BYTE_VEX3  = 8'hC4;
   localparam logic [7:0] BYTE_EVEX  = 8'h62;
   localparam logic [3:0] REX_HIGH   = 4'h4;

   // encoding kinds
   localparam logic [1:0] KIND_LEGACY = 2'd0;
   localparam logic [1:0] KIND_REX    = 2'd1;
   localparam logic [1:0] KIND_VEX    = 2'd2;
   localparam logic [1:0] KIND_EVEX   = 2'd3;

   // rep field codes
   localparam logic [1:0] REP_F2 = 2'd1;
   localparam logic [1:0] REP_F3 = 2'd2;

   // segment codes
   localparam logic [2:0] SEG_ES = 3'd0;
   localparam logic [2:0] SEG_CS = 3'd1;
   localparam logic [2:0] SEG_SS = 3'd2;
   localparam logic [2:0] SEG_DS = 3'd3;
   localparam logic [2:0] SEG_FS = 3'd4;
   localparam logic [2:0] SEG_GS = 3'd5;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_TRUNCATED = 1'b1;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [8:0] legacy_flags;
      logic [1:0] encoding_kind;
      logic [3:0] rex_wrxb;
      logic [4:0] vex_vvvv;
      logic [4:0] vex_map;
      logic [1:0] vex_pp;
      logic       vex_l;
      logic [7:0] evex_fields;
      logic [7:0] opcode_byte;
      logic       opcode_present;
   } rsp_type;

endpackage

// ===== rtl/pfxd_req_if.sv =====
interface pfxd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_data;

   modport source (output valid, output byte_value, output end_of_data, input ready);
   modport sink (input valid, input byte_value, input end_of_data, output ready);
endinterface

// ===== rtl/pfxd_rsp_if.sv =====
interface pfxd_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [8:0] legacy_flags;
   logic [1:0] encoding_kind;
   logic [3:0] rex_wrxb;
   logic [4:0] vex_vvvv;
   logic [4:0] vex_map;
   logic [1:0] vex_pp;
   logic       vex_l;
   logic [7:0] evex_fields;
   logic [7:0] opcode_byte;
   logic       opcode_present;

   modport source (
      output valid, input ready,
      output status, output legacy_flags, output encoding_kind, output rex_wrxb,
      output vex_vvvv, output vex_map, output vex_pp, output vex_l,
      output evex_fields, output opcode_byte, output opcode_present
   );
   modport sink (
      input valid, output ready,
      input status, input legacy_flags, input encoding_kind, input rex_wrxb,
      input vex_vvvv, input vex_map, input vex_pp, input vex_l,
      input evex_fields, input opcode_byte, input opcode_present
   );
endinterface

// ===== rtl/pfxd_core.sv =====
module pfxd_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  pfxd_pkg::req_type beat,
   output logic              emit,
   output pfxd_pkg::rsp_type rec
);
   import pfxd_pkg::*;

   localparam logic [2:0] PH_PREFIX = 3'd0;
   localparam logic [2:0] PH_VEX2   = 3'd1;
   localparam logic [2:0] PH_VEX3A  = 3'd2;
   localparam logic [2:0] PH_VEX3B  = 3'd3;
   localparam logic [2:0] PH_EVEXA  = 3'd4;
   localparam logic [2:0] PH_EVEXB  = 3'd5;
   localparam logic [2:0] PH_EVEXC  = 3'd6;

   logic [2:0] phase_ff, phase_in;
   logic [8:0] legacy_ff, legacy_in;
   logic [3:0] rex_ff, rex_in;
   logic       rex_valid_ff, rex_valid_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;

   logic [7:0] b;
   logic [1:0] ll;

   assign b  = beat.byte_value;
   assign ll = b[6:5];

   always_comb begin
      phase_in     = phase_ff;
      legacy_in    = legacy_ff;
      rex_in       = rex_ff;
      rex_valid_in = rex_valid_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      emit         = 1'b0;
      rec          = '0;
      rec.legacy_flags = legacy_ff;

      if (beat.end_of_data) begin
         emit       = 1'b1;
         rec.status = STATUS_TRUNCATED;
      end else begin
         case (phase_ff)
            PH_VEX2: begin
               emit              = 1'b1;
               rec.encoding_kind = KIND_VEX;
               rec.rex_wrxb      = {1'b0, ~b[7], 2'b00};
               rec.vex_vvvv      = {1'b0, ~b[6:3]};
               rec.vex_map       = 5'd1;
               rec.vex_pp        = b[1:0];
               rec.vex_l         = b[2];
            end
            PH_VEX3A: begin
               first_in = b;
               phase_in = PH_VEX3B;
            end
            PH_VEX3B: begin
               emit              = 1'b1;
               rec.encoding_kind = KIND_VEX;
               rec.rex_wrxb      = {b[7], ~first_ff[7:5]};
               rec.vex_vvvv      = {1'b0, ~b[6:3]};
               rec.vex_map       = first_ff[4:0];
               rec.vex_pp        = b[1:0];
               rec.vex_l         = b[2];
            end
            PH_EVEXA: begin
               first_in = b;
               phase_in = PH_EVEXB;
            end
            PH_EVEXB: begin
               second_in = b;
               phase_in  = PH_EVEXC;
            end
            PH_EVEXC: begin
               emit              = 1'b1;
               rec.encoding_kind = KIND_EVEX;
               rec.rex_wrxb      = {second_ff[7], ~first_ff[7:5]};
               rec.vex_vvvv      = {~b[3], ~second_ff[6:3]};
               rec.vex_map       = {2'b00, first_ff[2:0]};
               rec.vex_pp        = second_ff[1:0];
               rec.vex_l         = (ll == 2'd1);
               rec.evex_fields   = {b[7], ll, b[4], ~first_ff[4], b[2:0]};
            end
            default: begin
               // prefix phase: legacy prefixes cancel a pending rex
               case (b)
                  BYTE_LOCK: begin
                     legacy_in[0] = 1'b1;
                     rex_valid_in = 1'b0;
                  end
                  BYTE_REPNE: begin
                     legacy_in[2:1] = REP_F2;
                     rex_valid_in   = 1'b0;
                  end
                  BYTE_REP: begin
                     legacy_in[2:1] = REP_F3;
                     rex_valid_in   = 1'b0;
                  end
                  BYTE_SEGES: begin
                     legacy_in[6:3] = {SEG_ES, 1'b1};
                     rex_valid_in   = 1'b0;
                  end
                  BYTE_SEGCS: begin
                     legacy_in[6:3] = {SEG_CS, 1'b1};
                     rex_valid_in   = 1'b0;
                  end
                  BYTE_SEGSS: begin
                     legacy_in[6:3] = {SEG_SS, 1'b1};
                     rex_valid_in   = 1'b0;
                  end
                  BYTE_SEGDS: begin
                     legacy_in[6:3] = {SEG_DS, 1'b1};
                     rex_valid_in   = 1'b0;
                  end
                  BYTE_SEGFS: begin
                     legacy_in[6:3] = {SEG_FS, 1'b1};
                     rex_valid_in   = 1'b0;
                  end
                  BYTE_SEGGS: begin
                     legacy_in[6:3] = {SEG_GS, 1'b1};
                     rex_valid_in   = 1'b0;
                  end
                  BYTE_OPSZ: begin
                     legacy_in[7] = 1'b1;
                     rex_valid_in = 1'b0;
                  end
                  BYTE_ADSZ: begin
                     legacy_in[8] = 1'b1;
                     rex_valid_in = 1'b0;
                  end
                  default: begin
                     if (b[7:4] == REX_HIGH) begin
                        rex_in       = b[3:0];
                        rex_valid_in = 1'b1;
                     end else if (!rex_valid_ff && legacy_ff[7] == 1'b0 &&
                                  legacy_ff[2:0] == 3'b000 &&
                                  (b == BYTE_VEX2 || b == BYTE_VEX3 || b == BYTE_EVEX)) begin
                        if (b == BYTE_VEX2) begin
                           phase_in = PH_VEX2;
                        end else if (b == BYTE_VEX3) begin
                           phase_in = PH_VEX3A;
                        end else begin
                           phase_in = PH_EVEXA;
                        end
                     end else begin
                        emit               = 1'b1;
                        rec.opcode_byte    = b;
                        rec.opcode_present = 1'b1;
                        if (rex_valid_ff) begin
                           rec.encoding_kind = KIND_REX;
                           rec.rex_wrxb      = rex_ff;
                        end
                     end
                  end
               endcase
            end
         endcase
      end

      // every record closes the instruction
      if (emit) begin
         phase_in     = PH_PREFIX;
         legacy_in    = '0;
         rex_in       = '0;
         rex_valid_in = 1'b0;
         first_in     = '0;
         second_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PREFIX;
         legacy_ff    <= '0;
         rex_ff       <= '0;
         rex_valid_ff <= 1'b0;
         first_ff     <= '0;
         second_ff    <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         legacy_ff    <= legacy_in;
         rex_ff       <= rex_in;
         rex_valid_ff <= rex_valid_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
      end
   end

endmodule

// ===== rtl/x86_64_prefix_decoder_unit.sv =====
// x86-64 prefix decoder: legacy prefixes, rex, vex and evex
//
// req_bus carries one instruction byte per beat (byte_value), or an
// end-of-data marker (end_of_data). rsp_bus carries one decode record per
// instruction: it goes out on the opcode byte, on the last vex/evex payload
// byte, or on end of data (status truncated). Prefix and payload bytes
// before that produce no beat on rsp_bus.
// An accepted byte lands in an input register and is decoded against the
// per-instruction state once the result register is free; a record, if any, is
// registered in the result register and shown on rsp_bus.
// One byte per cycle is sustained while rsp_bus takes records; the state update
// is a single level of decode between the input register and the result register.
// If the receiver stalls, the record holds in the result register while one
// more byte sits in the input register; req_bus.ready drops only when both
// are full.
// Reset (synchronous, active high) empties both registers and clears the
// prefix state, so the next byte starts a new instruction.
module x86_64_prefix_decoder_unit (
   input  logic      clock,
   input  logic      reset,
   pfxd_req_if.sink  req_bus,
   pfxd_rsp_if.source rsp_bus
);
   import pfxd_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;

   logic    out_free;
   logic    step;
   logic    emit;
   rsp_type rec;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || step;

   pfxd_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .beat  (in_ff),
      .emit  (emit),
      .rec   (rec)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_ff.byte_value  <= req_bus.byte_value;
         in_ff.end_of_data <= req_bus.end_of_data;
      end
      if (step && emit) begin
         out_ff <= rec;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.status         = out_ff.status;
   assign rsp_bus.legacy_flags   = out_ff.legacy_flags;
   assign rsp_bus.encoding_kind  = out_ff.encoding_kind;
   assign rsp_bus.rex_wrxb       = out_ff.rex_wrxb;
   assign rsp_bus.vex_vvvv       = out_ff.vex_vvvv;
   assign rsp_bus.vex_map        = out_ff.vex_map;
   assign rsp_bus.vex_pp         = out_ff.vex_pp;
   assign rsp_bus.vex_l          = out_ff.vex_l;
   assign rsp_bus.evex_fields    = out_ff.evex_fields;
   assign rsp_bus.opcode_byte    = out_ff.opcode_byte;
   assign rsp_bus.opcode_present = out_ff.opcode_present;

endmodule
